FILE: hdl/assert_macros.svh
// Assertion macros used by hmm_forward_likelihood_unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted during reset
`define AST_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, muted during reset
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/hfl_pkg.sv
// Types and constants for the HMM forward likelihood unit.
// No dependencies.
`default_nettype none
package hfl_pkg;

  localparam int PROB_W  = 16;
  localparam int MANT_W  = 32;
  localparam int EXP_W   = 20;
  localparam int SHIFT_W = 5;

  localparam logic [PROB_W-1:0] ONE_Q15 = 16'h8000;
  localparam logic [MANT_W-1:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [EXP_W-1:0]  EXP_MAX = 20'hF_FFFF;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_TRANS   = 2'd1,
    OP_EMIT    = 2'd2,
    OP_OBSERVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_NSTART,
    ST_NWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t         opcode;
    logic [2:0]  row_state;
    logic [3:0]  column_index;
    logic [15:0] prob_value;
    logic [3:0]  symbol;
    logic        first_symbol;
    logic        last_symbol;
  } cmd_word_t;

  typedef struct packed {
    logic [MANT_W-1:0] prob_mantissa;
    logic [EXP_W-1:0]  prob_exponent;
    logic              exponent_saturated;
  } res_word_t;

  typedef struct packed {
    logic               done;
    logic [SHIFT_W-1:0] shift;
  } norm_res_t;

endpackage
`default_nettype wire

FILE: hdl/hfl_tbl_mem.sv
// Model table memory: start, transition and emission entries in Q1.15.
// One write port, two registered read ports. Uses hfl_pkg.
`default_nettype none
module hfl_tbl_mem
  import hfl_pkg::*;
#(
  parameter int DEPTH = 200,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [PROB_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr_a,
  input  wire logic [AW-1:0]     raddr_b,
  output logic      [PROB_W-1:0] rdata_a,
  output logic      [PROB_W-1:0] rdata_b
);

  logic [PROB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

FILE: hdl/hfl_fwd_mem.sv
// Forward vector memory, two banks of Q1.31 entries (old and new vector).
// One write port, one registered read port. Uses hfl_pkg.
`default_nettype none
module hfl_fwd_mem
  import hfl_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [MANT_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [MANT_W-1:0] rdata
);

  logic [MANT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/hfl_norm.sv
// Normalization shift search: largest n <= 31 with sum * 2^n <= 2^31.
// Binary search, one bit of n per cycle. Uses hfl_pkg.
`default_nettype none
module hfl_norm
  import hfl_pkg::*;
#(
  parameter int SUM_W = 35
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] sum,
  output norm_res_t             res
);

  logic [SUM_W-1:0]   s;
  logic [SHIFT_W-1:0] n;
  logic [2:0]         cnt;
  logic               busy;
  logic               done;
  logic [SHIFT_W-1:0] cand;
  logic [SUM_W:0]     lim;
  logic               fits;

  assign cand = n | (SHIFT_W'(1) << cnt);
  // sum << cand <= 2^31  <=>  sum <= 2^(31-cand)
  assign lim  = (SUM_W+1)'(1) << (SHIFT_W'(31) - cand);
  assign fits = ({1'b0, s} <= lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 3'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s   <= sum;
      n   <= '0;
      cnt <= 3'(SHIFT_W - 1);
    end else if (busy) begin
      if (fits) begin
        n <= cand;
      end
      cnt <= cnt - 3'd1;
    end
  end

  assign res.done  = done;
  assign res.shift = n;

endmodule
`default_nettype wire

FILE: hdl/hmm_forward_likelihood_unit.sv
// Discrete HMM forward-algorithm scorer. A continuing observe word runs through
// the single multiply-accumulate path, which reads one transition entry and one
// forward entry per cycle from the table and forward memories, followed by a
// five-step normalization search. One word is worked on at a time; a finished
// result waits in the output register while the next word is taken. Uses
// hfl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hmm_forward_likelihood_unit
  import hfl_pkg::*;
#(
  parameter int NUM_STATES  = 8,
  parameter int NUM_SYMBOLS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire cmd_word_t cmd,
  output logic           res_valid,
  input  wire logic      res_ready,
  output res_word_t      res
);

  localparam int KW         = $clog2(NUM_STATES);
  localparam int TRANS_BASE = NUM_STATES;
  localparam int EM_BASE    = NUM_STATES + NUM_STATES * NUM_STATES;
  localparam int TBL_DEPTH  = EM_BASE + NUM_STATES * NUM_SYMBOLS;
  localparam int TA_W       = $clog2(TBL_DEPTH);
  localparam int FWD_DEPTH  = 2 * NUM_STATES;
  localparam int FA_W       = $clog2(FWD_DEPTH);
  localparam int SUM_W      = MANT_W + $clog2(NUM_STATES);
  localparam int P_W        = MANT_W + PROB_W;
  localparam int ACC_W      = P_W + KW;
  localparam int Q_W        = ACC_W + 1;
  localparam int QS_W       = Q_W - 15;
  localparam int MS_W       = SUM_W + 31;

  state_t st, st_next;

  // observe word context
  logic [3:0] sym_r;
  logic       sym_ok;
  logic       first_r;
  logic       last_r;

  // vector state
  logic               bank;
  logic               fwd_zero;
  logic [SHIFT_W-1:0] shift;
  logic [SUM_W-1:0]   sum;
  logic [EXP_W-1:0]   expo;
  logic               ovf;

  // issue counters
  logic [KW-1:0] kc, lc;
  logic          l_end, mac_last;

  // pipeline
  logic              v1, last1, v2, last2, v3, v4;
  logic [KW-1:0]     k1, k2, k3, k4;
  logic [P_W-1:0]    p;
  logic [PROB_W-1:0] em_p, emd;
  logic [ACC_W-1:0]  acc, accd, acc_sum;
  logic [Q_W-1:0]    q;
  logic [QS_W-1:0]   q_sh;
  logic [MANT_W-1:0] nv;
  logic              wr_last;

  // control
  logic accept, obs_accept, issue, norm_start, commit, load_out;
  norm_res_t nres;

  // memories
  logic              tbl_we;
  logic [TA_W-1:0]   tbl_waddr, rd_a, rd_b;
  logic [PROB_W-1:0] prob_c, tbl_a, tbl_b;
  logic [FA_W-1:0]   fwd_raddr, fwd_waddr;
  logic [MANT_W-1:0] fwd_rd, fwd_val;
  logic [62:0]       fwd_sh;
  logic [P_W-1:0]    mul_p;
  logic              row_ok;

  assign accept     = cmd_valid && cmd_ready;
  assign obs_accept = accept && (cmd.opcode == OP_OBSERVE);

  // ---- table writes ----
  assign prob_c = (cmd.prob_value > ONE_Q15) ? ONE_Q15 : cmd.prob_value;
  assign row_ok = int'(cmd.row_state) < NUM_STATES;

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = '0;
    unique case (cmd.opcode)
      OP_START: begin
        tbl_we    = accept && row_ok;
        tbl_waddr = TA_W'(int'(cmd.row_state));
      end
      OP_TRANS: begin
        tbl_we    = accept && row_ok && (int'(cmd.column_index) < NUM_STATES);
        tbl_waddr = TA_W'(TRANS_BASE + int'(cmd.row_state) * NUM_STATES
                          + int'(cmd.column_index));
      end
      OP_EMIT: begin
        tbl_we    = accept && row_ok && (int'(cmd.column_index) < NUM_SYMBOLS);
        tbl_waddr = TA_W'(EM_BASE + int'(cmd.row_state) * NUM_SYMBOLS
                          + int'(cmd.column_index));
      end
      OP_OBSERVE: begin
        tbl_we    = 1'b0;
        tbl_waddr = '0;
      end
    endcase
  end

  // ---- read addresses for the issue stage ----
  assign rd_a = first_r ? TA_W'(int'(kc))
                        : TA_W'(TRANS_BASE + int'(lc) * NUM_STATES + int'(kc));
  assign rd_b = TA_W'(EM_BASE + int'(kc) * NUM_SYMBOLS + (sym_ok ? int'(sym_r) : 0));
  assign fwd_raddr = FA_W'((bank ? NUM_STATES : 0) + int'(lc));
  assign fwd_waddr = FA_W'((bank ? 0 : NUM_STATES) + int'(k4));

  hfl_tbl_mem #(.DEPTH(TBL_DEPTH)) u_tbl (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (prob_c),
    .raddr_a (rd_a),
    .raddr_b (rd_b),
    .rdata_a (tbl_a),
    .rdata_b (tbl_b)
  );

  hfl_fwd_mem #(.DEPTH(FWD_DEPTH)) u_fwd (
    .clk   (clk),
    .we    (v4),
    .waddr (fwd_waddr),
    .wdata (nv),
    .raddr (fwd_raddr),
    .rdata (fwd_rd)
  );

  hfl_norm #(.SUM_W(SUM_W)) u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .sum   (sum),
    .res   (nres)
  );

  // ---- next state ----
  assign l_end    = first_r || (lc == KW'(NUM_STATES - 1));
  assign mac_last = l_end && (kc == KW'(NUM_STATES - 1));
  assign wr_last  = v4 && (k4 == KW'(NUM_STATES - 1));

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:   if (obs_accept) st_next = ST_MAC;
      ST_MAC:    if (mac_last) st_next = ST_DRAIN;
      ST_DRAIN:  if (wr_last) st_next = ST_NSTART;
      ST_NSTART: st_next = ST_NWAIT;
      ST_NWAIT:  if (nres.done) st_next = last_r ? ST_OUT : ST_IDLE;
      ST_OUT:    if (!res_valid || res_ready) st_next = ST_IDLE;
      default:   st_next = ST_IDLE;
    endcase
  end

  // ---- control outputs ----
  always_comb begin
    cmd_ready  = 1'b0;
    issue      = 1'b0;
    norm_start = 1'b0;
    commit     = 1'b0;
    load_out   = 1'b0;
    unique case (st)
      ST_IDLE:   cmd_ready  = 1'b1;
      ST_MAC:    issue      = 1'b1;
      ST_DRAIN:  ;
      ST_NSTART: norm_start = 1'b1;
      ST_NWAIT:  commit     = nres.done;
      ST_OUT:    load_out   = !res_valid || res_ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else     st <= st_next;
  end

  // ---- word context and issue counters ----
  always_ff @(posedge clk) begin
    if (obs_accept) begin
      sym_r   <= cmd.symbol;
      sym_ok  <= int'(cmd.symbol) < NUM_SYMBOLS;
      first_r <= cmd.first_symbol;
      last_r  <= cmd.last_symbol;
      kc      <= '0;
      lc      <= '0;
    end else if (issue) begin
      if (l_end) begin
        lc <= '0;
        kc <= kc + KW'(1);
      end else begin
        lc <= lc + KW'(1);
      end
    end
  end

  // ---- MAC pipeline ----
  assign fwd_sh  = {31'd0, fwd_rd} << shift;
  assign fwd_val = fwd_zero ? '0 : fwd_sh[MANT_W-1:0];
  assign mul_p   = P_W'(fwd_val) * P_W'(tbl_a);
  assign acc_sum = acc + ACC_W'(p);
  assign q_sh    = q[Q_W-1:15];
  assign nv      = (|q_sh[QS_W-1:31]) ? ONE_Q31 : q_sh[MANT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      acc <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2 && last2;
      v4 <= v3;
      if (v2) begin
        acc <= last2 ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    last1 <= l_end;
    k1    <= kc;
    last2 <= last1;
    k2    <= k1;
    // first symbol: start << 31 so that the emission stage yields start*em*2
    p     <= first_r ? {1'b0, tbl_a, 31'd0} : mul_p;
    em_p  <= sym_ok ? tbl_b : '0;
    if (v2 && last2) begin
      accd <= acc_sum;
      emd  <= em_p;
      k3   <= k2;
    end
    q  <= Q_W'(accd[ACC_W-1:15]) * Q_W'(emd);
    k4 <= k3;
  end

  // ---- vector state ----
  logic [EXP_W-1:0] base_e;
  logic             base_o;
  logic [EXP_W:0]   e_sum;
  logic             sum_zero;

  assign sum_zero = (sum == '0);
  assign base_e   = first_r ? '0 : expo;
  assign base_o   = first_r ? 1'b0 : ovf;
  assign e_sum    = {1'b0, base_e} + (EXP_W+1)'(nres.shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      bank     <= 1'b0;
      fwd_zero <= 1'b1;
      shift    <= '0;
      sum      <= '0;
      expo     <= '0;
      ovf      <= 1'b0;
    end else begin
      if (obs_accept) begin
        sum <= '0;
      end else if (v4) begin
        sum <= sum + SUM_W'(nv);
      end
      if (commit) begin
        bank     <= ~bank;
        fwd_zero <= 1'b0;
        shift    <= sum_zero ? '0 : nres.shift;
        if (sum_zero) begin
          expo <= base_e;
          ovf  <= base_o;
        end else if (e_sum >= {1'b0, EXP_MAX}) begin
          expo <= EXP_MAX;
          ovf  <= 1'b1;
        end else begin
          expo <= e_sum[EXP_W-1:0];
          ovf  <= base_o;
        end
      end
    end
  end

  // ---- result register ----
  logic [MS_W-1:0] mant_full;
  assign mant_full = MS_W'(sum) << shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.prob_mantissa      <= (|mant_full[MS_W-1:31]) ? ONE_Q31
                                                        : mant_full[MANT_W-1:0];
      res.prob_exponent      <= expo;
      res.exponent_saturated <= ovf;
    end
  end

  // ---- assertions ----
  `AST_IMPLY(a_wr_phase, clk, rst, v4, (st == ST_MAC || st == ST_DRAIN), "fwd write outside MAC")
  `AST_NEXT(a_wr_last, clk, rst, wr_last, (st == ST_NSTART), "norm not started after vector")
  `AST_IMPLY(a_norm_done, clk, rst, nres.done, (st == ST_NWAIT), "norm done out of phase")
  `AST_IMPLY(a_ovf_max, clk, rst, ovf, (expo == EXP_MAX), "overflow without max exponent")

endmodule
`default_nettype wire

FILE: test/tb_hmm_forward_likelihood_unit.sv
// Self-checking testbench for hmm_forward_likelihood_unit: directed table, then random
// table loads and observation sequences, checked against an in-bench forward predictor.
// Depends on hfl_pkg and the unit RTL.
`timescale 1ns / 1ps
module tb_hmm_forward_likelihood_unit;
  import hfl_pkg::*;

  localparam int NS = 8;
  localparam int NSYM = 16;
  localparam int RANDOM_WORDS = 1200;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic res_ready = 1'b0;
  cmd_word_t cmd = '0;
  logic cmd_ready, res_valid;
  res_word_t res;

  always #6 clk = ~clk;

  hmm_forward_likelihood_unit DUT (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // predictor state
  logic [15:0] start_p [NS];
  logic [15:0] trans_p [NS][NS];
  logic [15:0] emit_p [NS][NSYM];
  logic [63:0] fwd [NS];
  logic [19:0] scale_exp;
  logic        exp_sat;
  bit          start_ok [NS];
  bit          trans_ok [NS][NS];
  bit          emit_ok [NS][NSYM];

  res_word_t expected_q[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_res = 0;
  int idle_pct = 9;

  function automatic logic [63:0] sat31(logic [63:0] v);
    return (v > 64'h8000_0000) ? 64'h8000_0000 : v;
  endfunction

  task automatic predict_word(cmd_word_t w);
    logic [15:0] p;
    logic [63:0] nxt [NS];
    logic [63:0] acc, em, s;
    int n;
    logic [20:0] e;
    res_word_t r;
    p = (w.prob_value > ONE_Q15) ? ONE_Q15 : w.prob_value;
    case (w.opcode)
      OP_START: begin
        start_p[w.row_state] = p; start_ok[w.row_state] = 1;
      end
      OP_TRANS: begin
        if (w.column_index < NS) begin
          trans_p[w.row_state][w.column_index] = p;
          trans_ok[w.row_state][w.column_index] = 1;
        end
      end
      OP_EMIT: begin
        emit_p[w.row_state][w.column_index] = p; emit_ok[w.row_state][w.column_index] = 1;
      end
      default: begin
        for (int k = 0; k < NS; k++) begin
          em = 64'(emit_p[k][w.symbol]);
          if (w.first_symbol) nxt[k] = (64'(start_p[k]) * em) << 1;
          else begin
            acc = 0;
            for (int l = 0; l < NS; l++) acc += fwd[l] * 64'(trans_p[l][k]);
            acc >>= 15;
            nxt[k] = (acc * em) >> 15;
          end
          nxt[k] = sat31(nxt[k]);
        end
        for (int k = 0; k < NS; k++) fwd[k] = nxt[k];
        if (w.first_symbol) begin
          scale_exp = 0; exp_sat = 0;
        end
        s = 0;
        for (int k = 0; k < NS; k++) s += fwd[k];
        if (s != 0) begin
          n = 0;
          while (n < 31 && (s << (n + 1)) <= 64'h8000_0000) n++;
          for (int k = 0; k < NS; k++) fwd[k] = fwd[k] << n;
          e = 21'(scale_exp) + 21'(n);
          if (e >= 21'(EXP_MAX)) begin
            e = 21'(EXP_MAX); exp_sat = 1;
          end
          scale_exp = e[19:0];
        end
        if (w.last_symbol) begin
          s = 0;
          for (int k = 0; k < NS; k++) s += fwd[k];
          r.prob_mantissa = 32'(sat31(s));
          r.prob_exponent = scale_exp;
          r.exponent_saturated = exp_sat;
          expected_q.push_back(r);
        end
      end
    endcase
  endtask

  function automatic bit tables_ready(cmd_word_t w);
    if (w.opcode != OP_OBSERVE) return 1;
    for (int k = 0; k < NS; k++) begin
      if (!emit_ok[k][w.symbol]) return 0;
      if (w.first_symbol && !start_ok[k]) return 0;
      if (!w.first_symbol) for (int l = 0; l < NS; l++) if (!trans_ok[l][k]) return 0;
    end
    return 1;
  endfunction

  // valid stays up across back-to-back words; it drops only in idle cycles
  task automatic send_word(cmd_word_t w);
    while (($urandom_range(99) < idle_pct)) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    predict_word(w);
    cmd <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  function automatic cmd_word_t mk(op_t op, int row, int col, int p, int sym, bit f, bit l);
    cmd_word_t w;
    w.opcode = op; w.row_state = 3'(row); w.column_index = 4'(col); w.prob_value = 16'(p);
    w.symbol = 4'(sym); w.first_symbol = f; w.last_symbol = l;
    return w;
  endfunction

  task automatic write_tables(bit skew);
    int p;
    for (int k = 0; k < NS; k++) begin
      p = skew ? $urandom_range(65535) : $urandom_range(32768);
      send_word(mk(OP_START, k, $urandom_range(15), p, $urandom_range(15),
                   $urandom_range(1), $urandom_range(1)));
      for (int j = 0; j < NS; j++)
        send_word(mk(OP_TRANS, k, j, skew ? $urandom_range(65535) : $urandom_range(4096),
                     $urandom_range(15), $urandom_range(1), $urandom_range(1)));
      for (int j = 0; j < NSYM; j++)
        send_word(mk(OP_EMIT, k, j, skew ? $urandom_range(65535) : $urandom_range(32768),
                     $urandom_range(15), $urandom_range(1), $urandom_range(1)));
    end
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // response side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) res_ready <= !hold_res && ($urandom_range(99) >= idle_pct);
    if (!rst && res_valid && res_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result exp=none act=%h", $time, res);
      end else begin
        if (res.prob_mantissa !== expected_q[0].prob_mantissa)
          $display("%0t: prob_mantissa exp=%h act=%h", $time,
                   expected_q[0].prob_mantissa, res.prob_mantissa);
        if (res.prob_exponent !== expected_q[0].prob_exponent)
          $display("%0t: prob_exponent exp=%h act=%h", $time,
                   expected_q[0].prob_exponent, res.prob_exponent);
        if (res.exponent_saturated !== expected_q[0].exponent_saturated)
          $display("%0t: exponent_saturated exp=%b act=%b", $time,
                   expected_q[0].exponent_saturated, res.exponent_saturated);
        if (res !== expected_q[0]) errors++;
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[hmm_forward_likelihood_unit] ERROR");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps going
  task automatic hold_off();
    hold_res = 1;
    repeat (600) @(posedge clk);
    hold_res = 0;
  endtask

  cmd_word_t dir_tab [$];
  res_word_t dir_exp [$];
  bit        dir_has [$];

  initial begin
    cmd_word_t w;
    int sent;
    for (int k = 0; k < NS; k++) begin
      start_p[k] = 0; fwd[k] = 0; start_ok[k] = 0;
      for (int j = 0; j < NS; j++) begin trans_p[k][j] = 0; trans_ok[k][j] = 0; end
      for (int j = 0; j < NSYM; j++) begin emit_p[k][j] = 0; emit_ok[k][j] = 0; end
    end
    scale_exp = 0; exp_sat = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tables first, so that the continuation below reads only written entries
    for (int k = 1; k < 7; k++) send_word(mk(OP_START, k, 0, 0, 0, 0, 0));
    for (int k = 0; k < NS; k++) begin
      for (int j = 0; j < NS; j++) send_word(mk(OP_TRANS, k, j, (j == k) ? 32768 : 0, 0, 0, 0));
      send_word(mk(OP_TRANS, k, 8 + k, 32768, 0, 0, 0));  // ignored column
      for (int j = 0; j < NSYM; j++) send_word(mk(OP_EMIT, k, j, (j & 1) ? 1 : 32768, 0, 0, 0));
    end

    // directed: extremes, clamping, continuation from the zero vector left by reset
    dir_tab = '{mk(OP_START, 0, 0, 32768, 0, 0, 0), mk(OP_START, 7, 15, 65535, 0, 1, 1),
                mk(OP_OBSERVE, 5, 3, 0, 0, 0, 1)};
    dir_exp = '{'0, '0, '{32'd0, 20'd0, 1'b0}};
    dir_has = '{0, 0, 1};
    for (int i = 0; i < dir_tab.size(); i++) begin
      send_word(dir_tab[i]);
      if (dir_has[i] && expected_q[$] !== dir_exp[i]) begin
        errors++;
        $display("%0t: directed row %0d exp=%h act=%h", $time, i, dir_exp[i], expected_q[$]);
      end
    end
    // tiny emission: drives the exponent up quickly
    send_word(mk(OP_OBSERVE, 0, 0, 0, 1, 1, 0));
    send_word(mk(OP_OBSERVE, 0, 0, 0, 1, 0, 0));
    send_word(mk(OP_OBSERVE, 0, 0, 0, 0, 0, 1));
    send_word(mk(OP_OBSERVE, 0, 0, 0, 0, 1, 1));
    wait_drained();

    // random part
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent % 400 == 0) begin
        write_tables($urandom_range(3) == 0);
        sent += NS * (1 + NS + NSYM);
      end
      if (sent > 300 && sent < 340) fork hold_off(); join_none
      idle_pct = (sent > 700 && sent < 900) ? 0 : 9;
      w = mk(OP_OBSERVE, $urandom_range(7), $urandom_range(15), $urandom_range(65535),
             $urandom_range(15), 1, $urandom_range(3) == 0);
      send_word(w);
      sent++;
      for (int j = $urandom_range(6); j > 0; j--) begin
        w = mk(OP_OBSERVE, $urandom_range(7), $urandom_range(15), $urandom_range(65535),
               $urandom_range(15), $urandom_range(15) == 0, $urandom_range(3) == 0);
        if (tables_ready(w)) begin send_word(w); sent++; end
      end
      w = mk(OP_OBSERVE, 0, 0, 0, $urandom_range(15), 0, 1);
      if (tables_ready(w)) begin send_word(w); sent++; end
      if ($urandom_range(9) == 0) begin
        // noise: single table writes, including clamped and ignored ones
        w = mk(op_t'($urandom_range(2)), $urandom_range(7), $urandom_range(15),
               $urandom_range(65535), $urandom_range(15), $urandom_range(1),
               $urandom_range(1));
        send_word(w);
        sent++;
      end
      if (sent > 1000 && sent < 1010) wait_drained();
    end

    wait_drained();
    if (errors == 0) $display("[hmm_forward_likelihood_unit] OK");
    else $display("[hmm_forward_likelihood_unit] ERROR");
    $finish;
  end
endmodule
